// ----- rtl/core/pinned_budget_residency_cache_unit_defines.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the pinned budget residency cache
// ----------------------------------------------------------------------------
`ifndef PINNED_BUDGET_RESIDENCY_CACHE_UNIT_DEFINES_SVH
`define PINNED_BUDGET_RESIDENCY_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PBRC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define PBRC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PBRC_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PBRC_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ----- rtl/core/pbrc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbrc_pkg
// types, codes and command structs shared by the cache unit
// ----------------------------------------------------------------------------
`default_nettype none
package pbrc_pkg;
  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] FN_BORROW  = 2'd0;
  localparam logic [1:0] FN_ADMIT   = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_BUDGET  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_NOHANDLE = 2'd3;

  localparam logic [11:0] BENEFIT_RST = 12'd192;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] tensor_key;
    logic [47:0] payload_handle;
    logic [39:0] resident_size;
    logic [39:0] stored_size;
    logic [39:0] new_budget;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  status;
    logic [47:0] out_handle;
    logic [39:0] byte_count;
    logic [39:0] resident_total;
    logic [39:0] pinned_total;
    logic [5:0]  entry_count;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [47:0] rejected_total;
    logic [47:0] avoided_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;      // capture input item
    logic scan_clr;  // restart scan at slot 0
    logic scan_step; // examine one slot, advance
    logic mul;       // register benefit products
    logic do_borrow;
    logic do_admit;
    logic do_release;
    logic do_budget;
    logic evict;     // remove chosen victim, emit notice
    logic move;      // copy last slot into hole
    logic final_out; // emit final item for release and set budget
  } ctl_t;

  typedef struct packed {
    logic       scan_done;
    logic [1:0] func;
    logic       found;
    logic       victim_found;
    logic       over_budget;
    logic       need_move;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/pbrc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbrc_ctrl
// sequencer: scan, operate, evict loop, final transaction
// ----------------------------------------------------------------------------
`default_nettype none
`include "pinned_budget_residency_cache_unit_defines.svh"
module pbrc_ctrl
  import pbrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output ctl_t      ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_VSCN = 3'd3;
  localparam logic [2:0] S_EVCT = 3'd4;
  localparam logic [2:0] S_MOVE = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.mul = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        unique case (sts.func)
          FN_BORROW: ctl.do_borrow = 1'b1;
          FN_ADMIT:  ctl.do_admit = 1'b1;
          FN_RELEASE: ctl.do_release = 1'b1;
          default:   ctl.do_budget = 1'b1;
        endcase
        if (sts.func == FN_BORROW || sts.func == FN_ADMIT ||
            (sts.func == FN_RELEASE && !sts.found)) begin
          state_nxt = S_FIN;
        end else begin
          ctl.scan_clr = 1'b1;
          state_nxt = S_VSCN;
        end
      end
      S_VSCN: begin
        if (!sts.over_budget) begin
          state_nxt = S_FIN;
        end else if (sts.scan_done) begin
          state_nxt = sts.victim_found ? S_EVCT : S_FIN;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_EVCT: begin
        ctl.evict = 1'b1;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        ctl.move = sts.need_move;
        ctl.scan_clr = 1'b1;
        state_nxt = S_VSCN;
      end
      S_FIN: begin
        ctl.final_out = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `PBRC_ASSERT_NXT(a_load_busy, clk, rst_n, ctl.load, busy)
  `PBRC_ASSERT_IMP(a_one_out, clk, rst_n, ctl.evict, !ctl.final_out)
  `PBRC_ASSERT_NXT(a_fin_idle, clk, rst_n, ctl.final_out, !busy)
endmodule
`default_nettype wire

// ----- rtl/core/pbrc_datapath.sv -----
// ----------------------------------------------------------------------------
// pbrc_datapath
// slot table, totals, one-slot-per-cycle scan, result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "pinned_budget_residency_cache_unit_defines.svh"
module pbrc_datapath
  import pbrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_t        ctl,
  output sts_t             sts,
  input  wire in_item_t    in_item,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_data,
  output logic             out_valid,
  output out_item_t        out_item
);
  logic [31:0] key_r [ENTRIES];
  logic [47:0] hdl_r [ENTRIES];
  logic [39:0] size_r [ENTRIES];
  logic [39:0] saved_r [ENTRIES];
  logic [31:0] hits_r [ENTRIES];
  logic [15:0] refs_r [ENTRIES];

  in_item_t    it_r;
  logic [11:0] benefit_r;
  logic [CNT_W-1:0] occ_r;
  logic [39:0] budget_r, res_r, pin_r;
  logic [31:0] hitc_r, missc_r;
  logic [47:0] rej_r, avd_r;

  logic [CNT_W-1:0] scan_r;
  logic             found_r, vfound_r;
  logic [IDX_W-1:0] idx_r, vidx_r;
  logic [47:0]      lhs_r;
  logic [51:0]      rhs_r;
  logic [IDX_W-1:0] last_r;

  logic             out_valid_r;
  out_item_t        out_r;

  logic [IDX_W-1:0] si;
  logic             in_range;
  logic             key_hit, hdl_hit, better;
  logic [IDX_W-1:0] fi;
  logic [IDX_W-1:0] vi;
  logic [39:0]      room;
  logic             enough, no_room;
  logic [39:0]      nb;
  logic [39:0]      vsz;

  assign si = scan_r[IDX_W-1:0];
  assign in_range = (scan_r < occ_r) && (scan_r < CNT_W'(ENTRIES));
  assign key_hit = in_range && (key_r[si] == it_r.tensor_key);
  assign hdl_hit = in_range && (hdl_r[si] == it_r.payload_handle);
  assign better = in_range && (refs_r[si] == 16'd0) &&
                  (!vfound_r || (hits_r[si] < hits_r[vidx_r]) ||
                   ((hits_r[si] == hits_r[vidx_r]) && (size_r[si] > size_r[vidx_r])));
  assign fi = idx_r;
  assign vi = vidx_r;
  assign vsz = size_r[vi];
  assign room = budget_r - res_r;
  assign enough = {4'd0, lhs_r} >= rhs_r;
  assign no_room = (res_r > budget_r) || (it_r.resident_size > room);
  assign nb = (it_r.new_budget < pin_r) ? pin_r : it_r.new_budget;

  assign sts.scan_done = !in_range;
  assign sts.func = it_r.func;
  assign sts.found = found_r;
  assign sts.victim_found = vfound_r;
  assign sts.over_budget = res_r > budget_r;
  assign sts.need_move = (vidx_r != last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      benefit_r <= BENEFIT_RST;
      occ_r <= '0;
      budget_r <= '0;
      res_r <= '0;
      pin_r <= '0;
      hitc_r <= '0;
      missc_r <= '0;
      rej_r <= '0;
      avd_r <= '0;
      out_valid_r <= 1'b0;
      scan_r <= '0;
      found_r <= 1'b0;
      vfound_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        benefit_r <= cfg_data;
      end
      if (ctl.load) begin
        it_r <= in_item;
        scan_r <= '0;
        found_r <= 1'b0;
        vfound_r <= 1'b0;
      end
      if (ctl.scan_clr) begin
        scan_r <= '0;
        vfound_r <= 1'b0;
      end
      if (ctl.mul) begin
        lhs_r <= {it_r.stored_size, 8'd0};
        rhs_r <= 52'(it_r.resident_size) * 52'(benefit_r);
      end
      if (ctl.scan_step && in_range) begin
        scan_r <= scan_r + CNT_W'(1);
        if (!found_r && ((it_r.func == FN_RELEASE) ? hdl_hit : key_hit)) begin
          found_r <= 1'b1;
          idx_r <= si;
        end
        if (better) begin
          vfound_r <= 1'b1;
          vidx_r <= si;
        end
      end
      if (ctl.do_borrow) begin
        out_valid_r <= 1'b1;
        out_r <= '0;
        out_r.last <= 1'b1;
        if (!found_r || size_r[fi] != it_r.resident_size) begin
          missc_r <= missc_r + 32'd1;
          out_r.status <= ST_MISS;
        end else begin
          if (refs_r[fi] == 16'd0) pin_r <= pin_r + size_r[fi];
          refs_r[fi] <= refs_r[fi] + 16'd1;
          hits_r[fi] <= hits_r[fi] + 32'd1;
          hitc_r <= hitc_r + 32'd1;
          avd_r <= avd_r + {8'd0, saved_r[fi]};
          out_r.status <= ST_OK;
          out_r.out_handle <= hdl_r[fi];
        end
      end
      if (ctl.do_admit) begin
        out_valid_r <= 1'b1;
        out_r <= '0;
        out_r.last <= 1'b1;
        out_r.status <= ST_REJECT;
        if (it_r.resident_size == 40'd0 || it_r.payload_handle == 48'd0) begin
        end else if (budget_r == 40'd0 || !enough || no_room || found_r) begin
          if (budget_r != 40'd0 && enough && !found_r && no_room)
            rej_r <= rej_r + {8'd0, it_r.resident_size};
        end else if (occ_r >= CNT_W'(ENTRIES)) begin
          rej_r <= rej_r + {8'd0, it_r.resident_size};
        end else begin
          key_r[occ_r[IDX_W-1:0]] <= it_r.tensor_key;
          hdl_r[occ_r[IDX_W-1:0]] <= it_r.payload_handle;
          size_r[occ_r[IDX_W-1:0]] <= it_r.resident_size;
          saved_r[occ_r[IDX_W-1:0]] <= it_r.stored_size;
          hits_r[occ_r[IDX_W-1:0]] <= 32'd0;
          refs_r[occ_r[IDX_W-1:0]] <= 16'd1;
          occ_r <= occ_r + CNT_W'(1);
          res_r <= res_r + it_r.resident_size;
          pin_r <= pin_r + it_r.resident_size;
          out_r.status <= ST_OK;
        end
      end
      if (ctl.do_release && found_r && refs_r[fi] != 16'd0) begin
        refs_r[fi] <= refs_r[fi] - 16'd1;
        if (refs_r[fi] == 16'd1)
          pin_r <= (pin_r >= size_r[fi]) ? pin_r - size_r[fi] : 40'd0;
      end
      if (ctl.do_budget) begin
        budget_r <= nb;
      end
      if (ctl.evict) begin
        res_r <= (res_r >= vsz) ? res_r - vsz : 40'd0;
        occ_r <= occ_r - CNT_W'(1);
        last_r <= IDX_W'(occ_r - CNT_W'(1));
        out_valid_r <= 1'b1;
        out_r.result_kind <= 1'b1;
        out_r.status <= ST_OK;
        out_r.out_handle <= hdl_r[vi];
        out_r.byte_count <= vsz;
        out_r.last <= 1'b0;
      end
      if (ctl.move) begin
        key_r[vi] <= key_r[last_r];
        hdl_r[vi] <= hdl_r[last_r];
        size_r[vi] <= size_r[last_r];
        saved_r[vi] <= saved_r[last_r];
        hits_r[vi] <= hits_r[last_r];
        refs_r[vi] <= refs_r[last_r];
      end
      if (ctl.final_out && it_r.func != FN_BORROW && it_r.func != FN_ADMIT) begin
        out_valid_r <= 1'b1;
        out_r.result_kind <= 1'b0;
        out_r.status <= (it_r.func == FN_RELEASE && !found_r) ? ST_NOHANDLE : ST_OK;
        out_r.out_handle <= '0;
        out_r.byte_count <= (it_r.func == FN_BUDGET) ? budget_r : 40'd0;
        out_r.last <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_item = out_r;
    out_item.resident_total = res_r;
    out_item.pinned_total = pin_r;
    out_item.entry_count = occ_r;
    out_item.hit_total = hitc_r;
    out_item.miss_total = missc_r;
    out_item.rejected_total = rej_r;
    out_item.avoided_total = avd_r;
  end

  `PBRC_ASSERT_IMP(a_occ_max, clk, rst_n, 1'b1, occ_r <= CNT_W'(ENTRIES))
  `PBRC_ASSERT_IMP(a_evict_victim, clk, rst_n, ctl.evict, vfound_r && occ_r != '0)
  `PBRC_ASSERT_NXT(a_evict_out, clk, rst_n, ctl.evict, out_valid)
endmodule
`default_nettype wire

// ----- rtl/core/pinned_budget_residency_cache_unit.sv -----
// the table is scanned one slot a cycle; borrow and admit scan once, release (if the handle is
// found) and set budget then scan for a victim while over budget, evicting one per pass
// and rescanning after each eviction; with all entries pinned no victim is found
// throughput: one transaction at a time; start is taken from the first cycle busy is low
// results are shown one cycle each on out_valid; the receiver cannot stall
// reset: synchronous active low, clears totals and fill count, benefit threshold to 192
// ----------------------------------------------------------------------------
// pinned_budget_residency_cache_unit
// byte-budgeted residency table of reference-counted entries
// ----------------------------------------------------------------------------
`default_nettype none
module pinned_budget_residency_cache_unit
  import pbrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data,
  output logic             out_valid,
  output out_item_t        out_item
);
  ctl_t ctl;
  sts_t sts;
  logic busy_w;

  pbrc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy_w), .sts(sts), .ctl(ctl)
  );

  pbrc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .in_item(in_item),
    .cfg_we(cfg_valid), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  assign busy = busy_w;
  assign cfg_ready = 1'b1;
endmodule
`default_nettype wire
